[sv/hbc_pkg.sv]
`default_nettype none

package hbc_pkg;

  localparam int COORD_W    = 13;
  localparam int TPR_W      = 9;
  localparam int TAG_W      = 16;
  localparam int OFFSET_W   = 8;
  localparam int SLOT_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_CACHE_ENTRIES = 4;
  localparam int TILE_SIZE         = 16;
  localparam int TILE_ROW_STRIDE   = 16;
  localparam int TILE_SHIFT        = $clog2(TILE_SIZE);
  localparam int TILE_COORD_W      = COORD_W - TILE_SHIFT;
  localparam int PROD_W            = TILE_COORD_W + TPR_W;
  localparam int OFF_FULL_W        = 16;

  localparam logic [COORD_W-1:0] RST_FIELD_COUNT_X = 13'd4096;
  localparam logic [COORD_W-1:0] RST_FIELD_COUNT_Z = 13'd4096;
  localparam logic [TPR_W-1:0]   RST_TILES_PER_ROW = 9'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIELD_COUNT_X = 2'd0,
    REG_FIELD_COUNT_Z = 2'd1,
    REG_TILES_PER_ROW = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_z;
  } req_word_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] cell_offset;
    logic [TAG_W-1:0]    fetch_tile;
  } rsp_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] field_count_x;
    logic [COORD_W-1:0] field_count_z;
    logic [TPR_W-1:0]   tiles_per_row;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic calc;
  } addr_ctl_t;

endpackage

`default_nettype wire

[sv/heightfield_block_cache.sv]
`default_nettype none
// Height field tile lookup with a small fully associative tag store.
// req channel (valid/ready): one word holds cell_x and cell_z. Each coordinate
// is clamped to its field count minus one, split into tile and in-tile
// offset, and the tile index is looked up in the tags.
// rsp channel (valid/ready): hit, slot, cell_offset, fetch_tile. On a miss the
// tile has been written into the slot under the round-robin pointer and the
// consumer fetches fetch_tile into that slot.
// cfg channel (valid/ready, always ready): cfg_index selects field_count_x,
// field_count_z or tiles_per_row; other indexes are dropped. Write only
// while idle.
// Path: IDLE accepts the req word and registers the clamped coordinates, CALC
// registers tile and offset, SEARCH compares tags from slot 0 up until the
// first match or the last slot (a miss fills), DONE loads the rsp register.
// One tag is read from the tag RAM and compared per cycle. One word is in
// flight at a time and req_ready is high only when idle.
// The result sits in an output register; the next req word is accepted while
// it waits, and a stalled rsp only holds the finished search before loading.
// Reset: all tags invalid, pointer zero, config registers to their defaults.
// No clearing pass is needed.

module heightfield_block_cache #(
  parameter int CACHE_ENTRIES = hbc_pkg::DEF_CACHE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  hbc_pkg::req_word_t              req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output hbc_pkg::rsp_word_t              rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] ENTRY_LAST = IDX_W'(CACHE_ENTRIES - 1);

  hbc_pkg::state_t           st;
  hbc_pkg::state_t           st_next;
  hbc_pkg::cfg_t             cfg;
  hbc_pkg::addr_ctl_t        addr_ctl;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          idx_next;
  logic [IDX_W-1:0]          idx_inc;
  logic [IDX_W-1:0]          ptr;
  logic [IDX_W-1:0]          ptr_next;
  logic [IDX_W-1:0]          slot_idx;
  logic [IDX_W-1:0]          slot_idx_next;
  logic                      found;
  logic                      found_next;
  logic [IDX_W-1:0]          rd_addr;
  logic [hbc_pkg::TAG_W-1:0] rd_tag;
  logic [CACHE_ENTRIES-1:0]  tag_valid;
  logic                      tag_we;
  logic                      match;
  logic                      rsp_load;
  logic [hbc_pkg::TAG_W-1:0]    tile;
  logic [hbc_pkg::OFFSET_W-1:0] offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_count_x <= hbc_pkg::RST_FIELD_COUNT_X;
      cfg.field_count_z <= hbc_pkg::RST_FIELD_COUNT_Z;
      cfg.tiles_per_row <= hbc_pkg::RST_TILES_PER_ROW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbc_pkg::REG_FIELD_COUNT_X: cfg.field_count_x <= cfg_data;
        hbc_pkg::REG_FIELD_COUNT_Z: cfg.field_count_z <= cfg_data;
        hbc_pkg::REG_TILES_PER_ROW: cfg.tiles_per_row <= hbc_pkg::TPR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  hbc_addr_unit u_addr (
    .clk    (clk),
    .ctl    (addr_ctl),
    .req    (req),
    .cfg    (cfg),
    .tile   (tile),
    .offset (offset)
  );

  hbc_tag_store #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_tags (
    .clk     (clk),
    .rst     (rst),
    .we      (tag_we),
    .wr_addr (ptr),
    .wr_tag  (tile),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .valid   (tag_valid)
  );

  assign idx_inc = idx + 1'b1;
  assign match   = tag_valid[idx] && (rd_tag == tile);

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= hbc_pkg::ST_IDLE;
      ptr <= '0;
    end else begin
      st  <= st_next;
      ptr <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    found    <= found_next;
    slot_idx <= slot_idx_next;
  end

  always_comb begin
    st_next       = st;
    idx_next      = idx;
    ptr_next      = ptr;
    found_next    = found;
    slot_idx_next = slot_idx;
    rd_addr       = idx_inc;
    tag_we        = 1'b0;
    req_ready     = 1'b0;
    rsp_load      = 1'b0;
    addr_ctl      = '0;
    case (st)
      hbc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          addr_ctl.load = 1'b1;
          st_next       = hbc_pkg::ST_CALC;
        end
      end
      hbc_pkg::ST_CALC: begin
        addr_ctl.calc = 1'b1;
        rd_addr       = '0;
        idx_next      = '0;
        st_next       = hbc_pkg::ST_SEARCH;
      end
      hbc_pkg::ST_SEARCH: begin
        if (match) begin
          found_next    = 1'b1;
          slot_idx_next = idx;
          st_next       = hbc_pkg::ST_DONE;
        end else if (idx == ENTRY_LAST) begin
          found_next    = 1'b0;
          slot_idx_next = ptr;
          tag_we        = 1'b1;
          ptr_next      = (ptr == ENTRY_LAST) ? '0 : ptr + 1'b1;
          st_next       = hbc_pkg::ST_DONE;
        end else begin
          idx_next = idx_inc;
        end
      end
      hbc_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load = 1'b1;
          st_next  = hbc_pkg::ST_IDLE;
        end
      end
      default: st_next = hbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.hit         <= found;
      rsp.slot        <= hbc_pkg::SLOT_W'(slot_idx);
      rsp.cell_offset <= offset;
      rsp.fetch_tile  <= tile;
    end
  end

  // miss fill leaves the filled entry valid
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    tag_we |=> tag_valid[$past(ptr)])
    else $error("filled tag entry not valid");

  a_ptr_on_fill: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(ptr)) |-> $past(tag_we))
    else $error("replace pointer moved without a fill");

  a_no_fill_on_hit: assert property (@(posedge clk) disable iff (rst)
    tag_we |-> !match)
    else $error("fill while a tag matched");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (st == hbc_pkg::ST_SEARCH) |-> (idx <= ENTRY_LAST))
    else $error("search index past last entry");

endmodule

`default_nettype wire

[sv/hbc_addr_unit.sv]
`default_nettype none

module hbc_addr_unit (
  input  logic                            clk,
  input  hbc_pkg::addr_ctl_t              ctl,
  input  hbc_pkg::req_word_t              req,
  input  hbc_pkg::cfg_t                   cfg,
  output logic [hbc_pkg::TAG_W-1:0]       tile,
  output logic [hbc_pkg::OFFSET_W-1:0]    offset
);

  logic [hbc_pkg::COORD_W-1:0]      x;
  logic [hbc_pkg::COORD_W-1:0]      z;
  logic [hbc_pkg::COORD_W-1:0]      x_clamped;
  logic [hbc_pkg::COORD_W-1:0]      z_clamped;
  logic [hbc_pkg::TILE_COORD_W-1:0] tx;
  logic [hbc_pkg::TILE_COORD_W-1:0] tz;
  logic [hbc_pkg::TILE_SHIFT-1:0]   ox;
  logic [hbc_pkg::TILE_SHIFT-1:0]   oz;
  logic [hbc_pkg::PROD_W-1:0]       tile_sum;
  logic [hbc_pkg::OFF_FULL_W-1:0]   off_sum;

  function automatic logic [hbc_pkg::COORD_W-1:0] clamp(
    input logic [hbc_pkg::COORD_W-1:0] c,
    input logic [hbc_pkg::COORD_W-1:0] count
  );
    logic [hbc_pkg::COORD_W-1:0] last;
    last = (count == '0) ? '0 : count - 1'b1;
    return (c > last) ? last : c;
  endfunction

  assign x_clamped = clamp(req.cell_x, cfg.field_count_x);
  assign z_clamped = clamp(req.cell_z, cfg.field_count_z);

  assign tx = x[hbc_pkg::COORD_W-1:hbc_pkg::TILE_SHIFT];
  assign tz = z[hbc_pkg::COORD_W-1:hbc_pkg::TILE_SHIFT];
  assign ox = x[hbc_pkg::TILE_SHIFT-1:0];
  assign oz = z[hbc_pkg::TILE_SHIFT-1:0];

  assign tile_sum = hbc_pkg::PROD_W'(tz) * hbc_pkg::PROD_W'(cfg.tiles_per_row)
                  + hbc_pkg::PROD_W'(tx);
  assign off_sum  = hbc_pkg::OFF_FULL_W'(oz)
                  * hbc_pkg::OFF_FULL_W'(hbc_pkg::TILE_ROW_STRIDE)
                  + hbc_pkg::OFF_FULL_W'(ox);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x_clamped;
      z <= z_clamped;
    end
    if (ctl.calc) begin
      tile   <= hbc_pkg::TAG_W'(tile_sum);
      offset <= hbc_pkg::OFFSET_W'(off_sum);
    end
  end

endmodule

`default_nettype wire

[sv/hbc_tag_store.sv]
`default_nettype none

module hbc_tag_store #(
  parameter int CACHE_ENTRIES = hbc_pkg::DEF_CACHE_ENTRIES,
  parameter int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [hbc_pkg::TAG_W-1:0]  wr_tag,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [hbc_pkg::TAG_W-1:0]  rd_tag,
  output logic [CACHE_ENTRIES-1:0]   valid
);

  logic [hbc_pkg::TAG_W-1:0] mem [CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_tag;
    end
    rd_tag <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire
